@@ src/grp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// grp_pkg
// Shared constants, codes and the result type of the grid rectangle packer.
// ----------------------------------------------------------------------------
package grp_pkg;

   localparam int MAX_CUTS = 64;
   localparam int MAX_SIDE = 4096;

   localparam int IDX_W  = $clog2(MAX_CUTS);
   localparam int CNT_W  = IDX_W + 1;
   localparam int SIDE_W = 13;
   localparam int POS_W  = 12;
   localparam int STAT_W = 2;

   localparam logic [STAT_W-1:0] STAT_OK     = 2'd0;
   localparam logic [STAT_W-1:0] STAT_NOROOM = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL   = 2'd2;

   localparam logic OP_CLEAR = 1'b0;
   localparam logic OP_PLACE = 1'b1;

   localparam logic CSR_ATLAS_WIDTH  = 1'b0;
   localparam logic CSR_ATLAS_HEIGHT = 1'b1;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [POS_W-1:0]  pos_x;
      logic [POS_W-1:0]  pos_y;
      logic [SIDE_W-1:0] max_width;
      logic [SIDE_W-1:0] max_height;
   } grp_result_type;

endpackage
`default_nettype wire

@@ src/grp_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// grp_engine
// Sequencer over the cut-line memory and the occupancy memory: scan, check,
// split and mark for a place transaction, short init for a clear.
// ----------------------------------------------------------------------------
module grp_engine (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire                         operation,
   input  wire  [grp_pkg::SIDE_W-1:0]  icon_width,
   input  wire  [grp_pkg::SIDE_W-1:0]  icon_height,
   input  wire  [grp_pkg::SIDE_W-1:0]  atlas_width,
   input  wire  [grp_pkg::SIDE_W-1:0]  atlas_height,
   input  wire                         res_take,
   output logic                        idle,
   output logic                        res_valid,
   output grp_pkg::grp_result_type     result
);
   import grp_pkg::*;

   localparam logic [4:0] S_IDLE = 5'd0,  S_CLR  = 5'd1,  S_X0   = 5'd2,  S_X0D  = 5'd3,
                          S_X1   = 5'd4,  S_X1D  = 5'd5,  S_Y0   = 5'd6,  S_Y0D  = 5'd7,
                          S_Y1   = 5'd8,  S_Y1D  = 5'd9,  S_CK   = 5'd10, S_CKD  = 5'd11,
                          S_FND  = 5'd12, S_IX   = 5'd13, S_IXW  = 5'd14, S_IYC  = 5'd15,
                          S_IYCW = 5'd16, S_IYO  = 5'd17, S_IYOW = 5'd18, S_MK   = 5'd19,
                          S_MKW  = 5'd20, S_FIN  = 5'd21;

   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_CUTS);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   function automatic logic [MAX_CUTS-1:0] low_mask(input logic [CNT_W-1:0] n);
      logic [MAX_CUTS-1:0] m;
      if (n >= CNT_FULL) m = '1;
      else m = ({{(MAX_CUTS-1){1'b0}}, 1'b1} << n[IDX_W-1:0]) - {{(MAX_CUTS-1){1'b0}}, 1'b1};
      return m;
   endfunction

   // memories: x cuts at the lower half, y cuts at the upper half
   logic [SIDE_W-1:0]   cut_mem [0:2*MAX_CUTS-1];
   logic [MAX_CUTS-1:0] occ_mem [0:MAX_CUTS-1];

   logic [IDX_W:0]      cut_ra, cut_wa;
   logic                cut_we;
   logic [SIDE_W-1:0]   cut_wd, cut_rd_ff;
   logic [IDX_W-1:0]    occ_ra, occ_wa, occ_ra_ff;
   logic                occ_we, occ_vld_ff;
   logic [MAX_CUTS-1:0] occ_wd, occ_rd_ff, occ_word;

   logic [MAX_CUTS-1:0] row_vld_ff, row_vld_in;

   logic [4:0]          state_ff, state_in;
   logic                rsp_ff, rsp_in;
   logic [1:0]          clr_ff, clr_in;
   logic [SIDE_W-1:0]   w_ff, w_in, h_ff, h_in;
   logic [CNT_W-1:0]    xcnt_ff, xcnt_in, ycnt_ff, ycnt_in;
   logic [CNT_W-1:0]    x0_ff, x0_in, x1_ff, x1_in, y0_ff, y0_in, y1_ff, y1_in;
   logic [CNT_W-1:0]    idx_ff, idx_in, idx_m1;
   logic [SIDE_W-1:0]   xc0_ff, xc0_in, xc1_ff, xc1_in, yc0_ff, yc0_in, yc1_ff, yc1_in;
   logic [MAX_CUTS-1:0] col_ff, col_in;
   logic                ny_ff, ny_in;
   logic [SIDE_W-1:0]   lw_ff, lw_in, lh_ff, lh_in;
   logic [STAT_W-1:0]   st_ff, st_in;
   logic [POS_W-1:0]    px_ff, px_in, py_ff, py_in;

   logic [SIDE_W-1:0]   x_diff, y_diff, ext_x, ext_y;
   logic [MAX_CUTS-1:0] rmask, low_y1;
   logic                need_x, need_y;

   always_ff @(posedge clock) begin
      if (cut_we) cut_mem[cut_wa] <= cut_wd;
      cut_rd_ff <= cut_mem[cut_ra];
      if (occ_we) occ_mem[occ_wa] <= occ_wd;
      occ_rd_ff <= occ_mem[occ_ra];
      occ_vld_ff <= row_vld_ff[occ_ra];
      occ_ra_ff <= occ_ra;
   end

   // unwritten rows read as the cleared pattern: only cell (0,0) free
   assign occ_word = occ_vld_ff ? occ_rd_ff :
                     (occ_ra_ff == '0) ? ~{{(MAX_CUTS-1){1'b0}}, 1'b1} : '1;

   assign idx_m1 = idx_ff - CNT_ONE;
   assign x_diff = cut_rd_ff - xc0_ff;
   assign y_diff = cut_rd_ff - yc0_ff;
   assign ext_x  = xc1_ff - xc0_ff;
   assign ext_y  = yc1_ff - yc0_ff;
   assign need_x = ext_x > w_ff;
   assign need_y = ext_y > h_ff;
   assign low_y1 = low_mask(y1_ff);
   assign rmask  = low_y1 & ~low_mask(y0_ff);

   always_comb begin
      state_in = state_ff; rsp_in = rsp_ff; clr_in = clr_ff;
      w_in = w_ff; h_in = h_ff; xcnt_in = xcnt_ff; ycnt_in = ycnt_ff;
      x0_in = x0_ff; x1_in = x1_ff; y0_in = y0_ff; y1_in = y1_ff; idx_in = idx_ff;
      xc0_in = xc0_ff; xc1_in = xc1_ff; yc0_in = yc0_ff; yc1_in = yc1_ff;
      col_in = col_ff; ny_in = ny_ff; lw_in = lw_ff; lh_in = lh_ff;
      st_in = st_ff; px_in = px_ff; py_in = py_ff; row_vld_in = row_vld_ff;
      cut_ra = '0; cut_we = 1'b0; cut_wa = '0; cut_wd = '0;
      occ_ra = '0; occ_we = 1'b0; occ_wa = '0; occ_wd = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               w_in = icon_width;
               h_in = icon_height;
               if (operation == OP_CLEAR) begin
                  clr_in = '0; rsp_in = 1'b1; state_in = S_CLR;
               end else begin
                  x0_in = '0; state_in = S_X0;
               end
            end
         end
         S_CLR: begin
            cut_we = 1'b1;
            cut_wa = {clr_ff[1], {(IDX_W-1){1'b0}}, clr_ff[0]};
            cut_wd = clr_ff[0] ? (clr_ff[1] ? atlas_height : atlas_width) : '0;
            clr_in = clr_ff + 2'd1;
            if (clr_ff == 2'd3) begin
               xcnt_in = CNT_W'(2); ycnt_in = CNT_W'(2);
               row_vld_in = '0; lw_in = '0; lh_in = '0;
               st_in = STAT_OK; px_in = '0; py_in = '0;
               state_in = rsp_ff ? S_FIN : S_IDLE;
            end
         end
         S_X0: begin
            if (x0_ff >= xcnt_ff) begin
               st_in = STAT_NOROOM; px_in = '0; py_in = '0; state_in = S_FIN;
            end else begin
               cut_ra = {1'b0, x0_ff[IDX_W-1:0]}; occ_ra = x0_ff[IDX_W-1:0];
               state_in = S_X0D;
            end
         end
         S_X0D: begin
            xc0_in = cut_rd_ff; col_in = occ_word; x1_in = x0_ff; state_in = S_X1;
         end
         S_X1: begin
            if (x1_ff >= xcnt_ff) begin
               x0_in = x0_ff + CNT_ONE; state_in = S_X0;
            end else begin
               cut_ra = {1'b0, x1_ff[IDX_W-1:0]}; state_in = S_X1D;
            end
         end
         S_X1D: begin
            if (x_diff >= w_ff) begin
               xc1_in = cut_rd_ff; y0_in = '0; state_in = S_Y0;
            end else begin
               x1_in = x1_ff + CNT_ONE; state_in = S_X1;
            end
         end
         S_Y0: begin
            if (y0_ff >= ycnt_ff) begin
               x0_in = x0_ff + CNT_ONE; state_in = S_X0;
            end else if (col_ff[y0_ff[IDX_W-1:0]]) begin
               y0_in = y0_ff + CNT_ONE;
            end else begin
               cut_ra = {1'b1, y0_ff[IDX_W-1:0]}; state_in = S_Y0D;
            end
         end
         S_Y0D: begin
            yc0_in = cut_rd_ff; y1_in = y0_ff; state_in = S_Y1;
         end
         S_Y1: begin
            if (y1_ff >= ycnt_ff) begin
               y0_in = y0_ff + CNT_ONE; state_in = S_Y0;
            end else begin
               cut_ra = {1'b1, y1_ff[IDX_W-1:0]}; state_in = S_Y1D;
            end
         end
         S_Y1D: begin
            if (y_diff >= h_ff) begin
               yc1_in = cut_rd_ff; idx_in = x0_ff; state_in = S_CK;
            end else begin
               y1_in = y1_ff + CNT_ONE; state_in = S_Y1;
            end
         end
         S_CK: begin
            if (idx_ff >= x1_ff) state_in = S_FND;
            else begin
               occ_ra = idx_ff[IDX_W-1:0]; state_in = S_CKD;
            end
         end
         S_CKD: begin
            if ((occ_word & rmask) != '0) begin
               y0_in = y0_ff + CNT_ONE; state_in = S_Y0;
            end else begin
               idx_in = idx_ff + CNT_ONE; state_in = S_CK;
            end
         end
         S_FND: begin
            if ((need_x && xcnt_ff >= CNT_FULL) || (need_y && ycnt_ff >= CNT_FULL)) begin
               st_in = STAT_FULL; px_in = '0; py_in = '0; state_in = S_FIN;
            end else begin
               px_in = xc0_ff[POS_W-1:0]; py_in = yc0_ff[POS_W-1:0]; ny_in = need_y;
               if (need_x) begin
                  idx_in = xcnt_ff; state_in = S_IX;
               end else if (need_y) begin
                  idx_in = ycnt_ff; state_in = S_IYC;
               end else begin
                  idx_in = x0_ff; state_in = S_MK;
               end
            end
         end
         // shift columns up from the new cut, copying the column below it
         S_IX: begin
            if (idx_ff < x1_ff) begin
               xcnt_in = xcnt_ff + CNT_ONE;
               if (ny_ff) begin
                  idx_in = ycnt_ff; state_in = S_IYC;
               end else begin
                  idx_in = x0_ff; state_in = S_MK;
               end
            end else begin
               cut_ra = {1'b0, idx_m1[IDX_W-1:0]}; occ_ra = idx_m1[IDX_W-1:0];
               state_in = S_IXW;
            end
         end
         S_IXW: begin
            cut_we = 1'b1; cut_wa = {1'b0, idx_ff[IDX_W-1:0]};
            cut_wd = (idx_ff == x1_ff) ? xc0_ff + w_ff : cut_rd_ff;
            occ_we = 1'b1; occ_wa = idx_ff[IDX_W-1:0]; occ_wd = occ_word;
            row_vld_in[idx_ff[IDX_W-1:0]] = 1'b1;
            idx_in = idx_m1; state_in = S_IX;
         end
         S_IYC: begin
            if (idx_ff < y1_ff) begin
               idx_in = '0; state_in = S_IYO;
            end else begin
               cut_ra = {1'b1, idx_m1[IDX_W-1:0]}; state_in = S_IYCW;
            end
         end
         S_IYCW: begin
            cut_we = 1'b1; cut_wa = {1'b1, idx_ff[IDX_W-1:0]};
            cut_wd = (idx_ff == y1_ff) ? yc0_ff + h_ff : cut_rd_ff;
            idx_in = idx_m1; state_in = S_IYC;
         end
         S_IYO: begin
            if (idx_ff >= xcnt_ff) begin
               ycnt_in = ycnt_ff + CNT_ONE; idx_in = x0_ff; state_in = S_MK;
            end else begin
               occ_ra = idx_ff[IDX_W-1:0]; state_in = S_IYOW;
            end
         end
         S_IYOW: begin
            // bits at and above the new row move up one, the new row copies the one below
            occ_we = 1'b1; occ_wa = idx_ff[IDX_W-1:0];
            occ_wd = (occ_word & low_y1) | ((occ_word << 1) & ~low_y1);
            row_vld_in[idx_ff[IDX_W-1:0]] = 1'b1;
            idx_in = idx_ff + CNT_ONE; state_in = S_IYO;
         end
         S_MK: begin
            if (idx_ff >= x1_ff) begin
               if (w_ff > lw_ff) lw_in = w_ff;
               if (h_ff > lh_ff) lh_in = h_ff;
               st_in = STAT_OK; state_in = S_FIN;
            end else begin
               occ_ra = idx_ff[IDX_W-1:0]; state_in = S_MKW;
            end
         end
         S_MKW: begin
            occ_we = 1'b1; occ_wa = idx_ff[IDX_W-1:0]; occ_wd = occ_word | rmask;
            row_vld_in[idx_ff[IDX_W-1:0]] = 1'b1;
            idx_in = idx_ff + CNT_ONE; state_in = S_MK;
         end
         S_FIN: begin
            if (res_take) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLR;
         rsp_ff     <= 1'b0;
         clr_ff     <= '0;
         row_vld_ff <= '0;
         xcnt_ff    <= CNT_W'(2);
         ycnt_ff    <= CNT_W'(2);
         lw_ff      <= '0;
         lh_ff      <= '0;
      end else begin
         state_ff   <= state_in;
         rsp_ff     <= rsp_in;
         clr_ff     <= clr_in;
         row_vld_ff <= row_vld_in;
         xcnt_ff    <= xcnt_in;
         ycnt_ff    <= ycnt_in;
         lw_ff      <= lw_in;
         lh_ff      <= lh_in;
      end
      w_ff <= w_in; h_ff <= h_in;
      x0_ff <= x0_in; x1_ff <= x1_in; y0_ff <= y0_in; y1_ff <= y1_in; idx_ff <= idx_in;
      xc0_ff <= xc0_in; xc1_ff <= xc1_in; yc0_ff <= yc0_in; yc1_ff <= yc1_in;
      col_ff <= col_in; ny_ff <= ny_in;
      st_ff <= st_in; px_ff <= px_in; py_ff <= py_in;
   end

   assign idle      = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_FIN);
   assign result    = '{status: st_ff, pos_x: px_ff, pos_y: py_ff,
                        max_width: lw_ff, max_height: lh_ff};

endmodule
`default_nettype wire

@@ src/grid_rectangle_packer_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// grid_rectangle_packer_top
// Texture atlas rectangle allocator over a grid of cut lines.
// ----------------------------------------------------------------------------
// One transaction at a time. A place scans the grid one cut-line step at a
// time and checks the covered columns for every free candidate cell. The
// split passes then visit each column moved above a new x cut, each y cut
// moved above a new y cut and each column rewritten for a new y cut, and
// marking visits each covered column. After reset the block is busy while it
// writes the initial cut lines; occupancy needs no clearing pass. Atlas size
// registers take effect at the next clear.
module grid_rectangle_packer_top (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_ready,
   input  wire                        req_operation,
   input  wire  [grp_pkg::SIDE_W-1:0] req_icon_width,
   input  wire  [grp_pkg::SIDE_W-1:0] req_icon_height,
   output logic                       rsp_valid,
   input  wire                        rsp_ready,
   output logic [grp_pkg::STAT_W-1:0] rsp_status,
   output logic [grp_pkg::POS_W-1:0]  rsp_pos_x,
   output logic [grp_pkg::POS_W-1:0]  rsp_pos_y,
   output logic [grp_pkg::SIDE_W-1:0] rsp_max_width,
   output logic [grp_pkg::SIDE_W-1:0] rsp_max_height,
   input  wire                        csr_we,
   input  wire                        csr_index,
   input  wire  [grp_pkg::SIDE_W-1:0] csr_wdata
);
   import grp_pkg::*;

   localparam logic [SIDE_W-1:0] SIDE_LIMIT = SIDE_W'(MAX_SIDE);
   localparam logic [SIDE_W-1:0] SIDE_RESET = SIDE_W'(1024);

   logic [SIDE_W-1:0] aw_ff, aw_in, ah_ff, ah_in, aw_eff, ah_eff;
   logic              rsp_valid_ff, rsp_valid_in;
   grp_result_type    rsp_ff, rsp_in, eng_result;
   logic              eng_idle, eng_res_valid, eng_take, start;

   always_comb begin
      aw_in = aw_ff;
      ah_in = ah_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_ATLAS_WIDTH:  aw_in = csr_wdata;
            CSR_ATLAS_HEIGHT: ah_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign aw_eff = (aw_ff > SIDE_LIMIT) ? SIDE_LIMIT : aw_ff;
   assign ah_eff = (ah_ff > SIDE_LIMIT) ? SIDE_LIMIT : ah_ff;

   assign req_ready = eng_idle;
   assign start     = req_valid && eng_idle;
   assign eng_take  = !rsp_valid_ff || rsp_ready;

   grp_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .operation    (req_operation),
      .icon_width   (req_icon_width),
      .icon_height  (req_icon_height),
      .atlas_width  (aw_eff),
      .atlas_height (ah_eff),
      .res_take     (eng_take),
      .idle         (eng_idle),
      .res_valid    (eng_res_valid),
      .result       (eng_result)
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (eng_res_valid && eng_take) begin
         rsp_in       = eng_result;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aw_ff        <= SIDE_RESET;
         ah_ff        <= SIDE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         aw_ff        <= aw_in;
         ah_ff        <= ah_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_ff.status;
   assign rsp_pos_x      = rsp_ff.pos_x;
   assign rsp_pos_y      = rsp_ff.pos_y;
   assign rsp_max_width  = rsp_ff.max_width;
   assign rsp_max_height = rsp_ff.max_height;

   // the engine is busy in the cycle after it accepts a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("engine idle right after accepting a transaction");

   // a result handed over by the engine lands in the output register
   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      eng_res_valid && eng_take |=> rsp_valid)
      else $error("engine result lost");

   // a result is never reported as both placed with an offset and failed
   a_fail_zero_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STAT_OK |-> rsp_pos_x == '0 && rsp_pos_y == '0)
      else $error("failed request carries a position");

endmodule
`default_nettype wire

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid rectangle packer. Place and clear
// transactions are checked field by field against a cut-line grid predictor.
// ----------------------------------------------------------------------------
module tb;
   import grp_pkg::*;

   localparam int IDLE_LIMIT = 5000000;

   typedef struct packed {
      logic              operation;
      logic [SIDE_W-1:0] icon_width;
      logic [SIDE_W-1:0] icon_height;
   } packer_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_operation = OP_CLEAR;
   logic [SIDE_W-1:0] req_icon_width = '0;
   logic [SIDE_W-1:0] req_icon_height = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [STAT_W-1:0] rsp_status;
   logic [POS_W-1:0]  rsp_pos_x;
   logic [POS_W-1:0]  rsp_pos_y;
   logic [SIDE_W-1:0] rsp_max_width;
   logic [SIDE_W-1:0] rsp_max_height;
   logic              csr_we = 1'b0;
   logic              csr_index = CSR_ATLAS_WIDTH;
   logic [SIDE_W-1:0] csr_wdata = '0;

   grid_rectangle_packer_top i_dut (.*);

   // predictor state
   logic [SIDE_W-1:0] cfg_width, cfg_height;
   int                xcut[MAX_CUTS];
   int                ycut[MAX_CUTS];
   int                nx, ny;
   bit                occ[MAX_CUTS][MAX_CUTS];
   int                big_w, big_h;

   packer_req_type pending_reqs[$];
   grp_result_type expected_results[$];

   int  errors = 0;
   int  n_norm = 0, n_noroom = 0, n_full = 0;
   int  n_queued = 0, n_seen = 0;
   int  idle_cycles = 0;
   int  req_gap = 0, rsp_gap = 0;

   function automatic int clamp_side(int v);
      return v > MAX_SIDE ? MAX_SIDE : v;
   endfunction

   function automatic void atlas_clear();
      big_w = 0;
      big_h = 0;
      for (int i = 0; i < MAX_CUTS; i++) begin
         xcut[i] = 0;
         ycut[i] = 0;
         for (int j = 0; j < MAX_CUTS; j++) occ[i][j] = 1'b1;
      end
      xcut[1] = clamp_side(cfg_width);
      ycut[1] = clamp_side(cfg_height);
      nx = 2;
      ny = 2;
      occ[0][0] = 1'b0;
   endfunction

   function automatic void split_column(int p, int v);
      for (int i = nx; i > p; i--) begin
         xcut[i] = xcut[i-1];
         for (int j = 0; j < MAX_CUTS; j++) occ[i][j] = occ[i-1][j];
      end
      xcut[p] = v;
      for (int j = 0; j < MAX_CUTS; j++) occ[p][j] = occ[p-1][j];
      nx++;
   endfunction

   function automatic void split_row(int p, int v);
      for (int i = ny; i > p; i--) begin
         ycut[i] = ycut[i-1];
         for (int a = 0; a < MAX_CUTS; a++) occ[a][i] = occ[a][i-1];
      end
      ycut[p] = v;
      for (int a = 0; a < MAX_CUTS; a++) occ[a][p] = occ[a][p-1];
      ny++;
   endfunction

   function automatic grp_result_type allocate(packer_req_type r);
      grp_result_type res;
      int  w, h, x1, y1;
      bit  blocked, done, need_x, need_y;
      w = r.icon_width;
      h = r.icon_height;
      res = '0;
      res.status = STAT_NOROOM;
      done = 1'b0;
      if (r.operation == OP_CLEAR) begin
         atlas_clear();
         res.status = STAT_OK;
      end else begin
         for (int x0 = 0; x0 < nx && !done; x0++) begin
            for (int y0 = 0; y0 < ny && !done; y0++) begin
               if (occ[x0][y0]) continue;
               x1 = x0;
               while (x1 < nx && xcut[x1] - xcut[x0] < w) x1++;
               y1 = y0;
               while (y1 < ny && ycut[y1] - ycut[y0] < h) y1++;
               if (x1 >= nx || y1 >= ny) continue;
               blocked = 1'b0;
               for (int a = x0; a < x1; a++)
                  for (int b = y0; b < y1; b++)
                     if (occ[a][b]) blocked = 1'b1;
               if (blocked) continue;
               done = 1'b1;
               need_x = (xcut[x1] - xcut[x0] > w) && x1 > 0;
               need_y = (ycut[y1] - ycut[y0] > h) && y1 > 0;
               if ((need_x && nx >= MAX_CUTS) || (need_y && ny >= MAX_CUTS)) begin
                  res.status = STAT_FULL;
               end else begin
                  res.status = STAT_OK;
                  res.pos_x = xcut[x0];
                  res.pos_y = ycut[y0];
                  if (need_x) split_column(x1, xcut[x0] + w);
                  if (need_y) split_row(y1, ycut[y0] + h);
                  for (int a = x0; a < x1; a++)
                     for (int b = y0; b < y1; b++) occ[a][b] = 1'b1;
                  if (w > big_w) big_w = w;
                  if (h > big_h) big_h = h;
               end
            end
         end
      end
      res.max_width = big_w;
      res.max_height = big_h;
      return res;
   endfunction

   function automatic int draw_gap();
      int k;
      k = $urandom_range(0, 99);
      if (k < 45) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
   endtask

   task automatic push_req(bit op, int w, int h);
      packer_req_type r;
      r.operation = op;
      r.icon_width = w;
      r.icon_height = h;
      pending_reqs = {pending_reqs, r};
      n_queued++;
   endtask

   task automatic write_csr(logic idx, int v);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_ATLAS_WIDTH) cfg_width = v;
      else cfg_height = v;
   endtask

   // wait until every queued transaction has its result, plus settle time
   task automatic drain();
      while (n_seen < n_queued)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // driver
   always @(posedge clock) begin
      grp_result_type predicted;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && req_ready) begin
         predicted = allocate({req_operation, req_icon_width, req_icon_height});
         expected_results = {expected_results, predicted};
         req_gap = draw_gap();
         if (req_gap == 0 && pending_reqs.size() != 0) begin
            {req_operation, req_icon_width, req_icon_height} <= pending_reqs.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end else if (!req_valid) begin
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_reqs.size() != 0) begin
            {req_operation, req_icon_width, req_icon_height} <= pending_reqs.pop_front();
            req_valid <= 1'b1;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      grp_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            n_seen++;
            if (expected_results.size() == 0) begin
               report_mismatch("queued results", 0, 1);
            end else begin
               want = expected_results.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_pos_x !== want.pos_x) report_mismatch("pos_x", rsp_pos_x, want.pos_x);
               if (rsp_pos_y !== want.pos_y) report_mismatch("pos_y", rsp_pos_y, want.pos_y);
               if (rsp_max_width !== want.max_width)
                  report_mismatch("max_width", rsp_max_width, want.max_width);
               if (rsp_max_height !== want.max_height)
                  report_mismatch("max_height", rsp_max_height, want.max_height);
               case (want.status)
                  STAT_OK:     n_norm++;
                  STAT_NOROOM: n_noroom++;
                  default:     n_full++;
               endcase
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else if (rsp_valid && rsp_ready) begin
            rsp_gap = draw_gap();
            rsp_ready <= (rsp_gap == 0);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // stimulus
   initial begin
      int w, h, k;
      cfg_width = 1024;
      cfg_height = 1024;
      atlas_clear();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: reset geometry, extremes, zero icons, clear
      push_req(OP_PLACE, 0, 0);
      push_req(OP_PLACE, 1024, 1024);
      push_req(OP_PLACE, 1, 1);
      push_req(OP_CLEAR, 8191, 8191);
      push_req(OP_PLACE, 8191, 8191);
      push_req(OP_PLACE, 4096, 1);
      push_req(OP_PLACE, 1, 4096);
      push_req(OP_PLACE, 512, 300);
      push_req(OP_PLACE, 512, 300);
      push_req(OP_PLACE, 600, 100);
      push_req(OP_PLACE, 0, 50);
      push_req(OP_CLEAR, 0, 0);
      drain();

      // register change only takes effect at the next clear
      write_csr(CSR_ATLAS_WIDTH, 8191);
      write_csr(CSR_ATLAS_HEIGHT, 0);
      push_req(OP_PLACE, 1000, 1000);
      push_req(OP_CLEAR, 0, 0);
      push_req(OP_PLACE, 1, 0);
      push_req(OP_PLACE, 0, 0);
      drain();
      write_csr(CSR_ATLAS_WIDTH, 4096);
      write_csr(CSR_ATLAS_HEIGHT, 4096);
      push_req(OP_CLEAR, 0, 0);
      push_req(OP_PLACE, 4096, 4096);
      push_req(OP_PLACE, 1, 1);
      drain();

      // cut-line capacity: narrow atlas filled with 1x1 icons
      write_csr(CSR_ATLAS_WIDTH, 200);
      write_csr(CSR_ATLAS_HEIGHT, 1);
      push_req(OP_CLEAR, 0, 0);
      for (int i = 0; i < 66; i++) push_req(OP_PLACE, 1, 1);
      drain();

      // random phases over several atlas sizes
      for (int ph = 0; ph < 4; ph++) begin
         case (ph)
            0: begin w = 1; h = 4096; end
            1: begin w = 64; h = 64; end
            2: begin w = $urandom_range(1, 8191); h = $urandom_range(1, 8191); end
            default: begin w = 256; h = 128; end
         endcase
         write_csr(CSR_ATLAS_WIDTH, w);
         write_csr(CSR_ATLAS_HEIGHT, h);
         push_req(OP_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
         for (int i = 0; i < 13; i++) begin
            k = $urandom_range(0, 99);
            if (k < 4) push_req(OP_CLEAR, $urandom_range(0, 8191), $urandom_range(0, 8191));
            else if (k < 12)
               push_req(OP_PLACE, $urandom_range(0, 8191), $urandom_range(0, 8191));
            else if (k < 70)
               push_req(OP_PLACE, $urandom_range(1, 24), $urandom_range(1, 24));
            else
               push_req(OP_PLACE, $urandom_range(1, 300), $urandom_range(1, 300));
         end
         drain();
      end

      $display("covered %0d results: %0d placed/cleared, %0d no room, %0d full",
               n_norm + n_noroom + n_full, n_norm, n_noroom, n_full);
      if (errors == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule
